// File: sv/bffa_pkg.sv
// bffa_pkg: shared field widths, operation and status codes for the
// bitmap first-fit allocator. No dependencies.
package bffa_pkg;

  // width of every number-like field on the ports
  localparam int FIELD_W  = 14;
  localparam int STATUS_W = 2;

  // request operation codes
  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // reset value of the limit register
  localparam logic [FIELD_W-1:0] LIMIT_RESET = FIELD_W'(8192);

endpackage

// File: sv/bitmap_first_fit_allocator_top.sv
// bitmap_first_fit_allocator_top: free map allocator, one map memory plus a
// word-full summary vector searched in two steps. Depends on bffa_pkg.
//
//  channel   signals                                  handshake
//  --------  ---------------------------------------  -----------------------
//  request   op, number                               start & !busy
//  result    result_number, status, free_count        done, one cycle, no stall
//  config    limit_wdata                              limit_we
//
// Allocate: group search, word search, map read, modify/write-back, then the
// done beat; when every word is full the result follows the group search.
// Release: map read, modify, result; out of range it answers in the cycle
// after accept and busy never rises. Otherwise busy is high from accept until
// the done beat, which shows while busy is already low. Reset is synchronous;
// per-word valid bits make the whole map read as free, no clearing pass.
module bitmap_first_fit_allocator_top #(
  parameter int MAP_BITS  = 8192,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [bffa_pkg::FIELD_W-1:0]  number,
  input  logic                          limit_we,
  input  logic [bffa_pkg::FIELD_W-1:0]  limit_wdata,
  output logic                          done,
  output logic [bffa_pkg::FIELD_W-1:0]  result_number,
  output logic [bffa_pkg::STATUS_W-1:0] status,
  output logic [bffa_pkg::FIELD_W-1:0]  free_count
);
  import bffa_pkg::*;

  // geometry (WORD_BITS is a power of two)
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int KW        = AW + BW;
  localparam int UW        = $clog2(MAP_BITS + 1);
  localparam int CW0       = (UW > FIELD_W) ? UW : FIELD_W;
  localparam int CW        = (CW0 > KW + 1) ? CW0 : KW + 1;
  localparam int GRP       = 16;
  localparam int GIW       = $clog2(GRP);
  localparam int NUM_GRP   = (MAP_WORDS + GRP - 1) / GRP;
  localparam int GW        = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRP,
    S_WORD,
    S_READ,
    S_MOD
  } state_t;

  state_t                  state;
  logic [FIELD_W-1:0]      limit;
  logic                    req_op;
  logic [CW-1:0]           lim_q;
  logic [UW-1:0]           used;
  logic [UW-1:0]           used_next;
  logic [GW-1:0]           gsel;
  logic [AW-1:0]           addr;
  logic [BW-1:0]           bsel;
  logic [MAP_WORDS-1:0]    full;
  logic [MAP_WORDS-1:0]    valid;
  logic                    rvalid;
  logic [WORD_BITS-1:0]    rdata;
  logic [WORD_BITS-1:0]    mem [MAP_WORDS];

  logic [CW-1:0]           num_ext;
  logic [CW-1:0]           n1;
  logic [CW-1:0]           eff_lim;
  logic [NUM_GRP*GRP-1:0]  fpad;
  logic [NUM_GRP-1:0]      gnf;
  logic [GW-1:0]           gidx;
  logic                    gany;
  logic [GRP-1:0]          gbits;
  logic [GIW-1:0]          gi;
  logic [GW+GIW-1:0]       widx;
  logic [WORD_BITS-1:0]    word;
  logic [BW-1:0]           bfree;
  logic [CW-1:0]           k_ext;
  logic                    alloc_fit;
  logic                    rel_hit;
  logic                    mem_we;
  logic [WORD_BITS-1:0]    wdata;

  // free numbers left, saturated at zero
  function automatic logic [CW-1:0] sat_free(input logic [CW-1:0] lim,
                                             input logic [UW-1:0] cnt);
    logic [CW-1:0] c;
    c = CW'(cnt);
    return (lim > c) ? (lim - c) : '0;
  endfunction

  assign busy = (state != S_IDLE);

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (limit_we) begin
      limit <= limit_wdata;
    end
  end

  // effective limit and release index
  always_comb begin
    num_ext = CW'(number);
    n1      = num_ext - CW'(1);
    eff_lim = (CW'(limit) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(limit);
  end

  // group search: lowest group holding a word that is not full
  always_comb begin
    for (int i = 0; i < NUM_GRP * GRP; i++) begin
      fpad[i] = (i < MAP_WORDS) ? full[i] : 1'b1;
    end
    for (int g = 0; g < NUM_GRP; g++) begin
      gnf[g] = ~&fpad[g*GRP +: GRP];
    end
    gidx = '0;
    gany = 1'b0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (gnf[g]) begin
        gidx = GW'(g);
        gany = 1'b1;
      end
    end
  end

  // word search inside the chosen group
  always_comb begin
    gbits = fpad[gsel*GRP +: GRP];
    gi    = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (!gbits[i]) begin
        gi = GIW'(i);
      end
    end
    widx = {gsel, gi};
  end

  // modify: lowest free bit on allocate, target bit on release
  always_comb begin
    word  = rvalid ? rdata : '0;
    bfree = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        bfree = BW'(i);
      end
    end
    k_ext     = CW'({addr, bfree});
    alloc_fit = (k_ext < lim_q);
    rel_hit   = word[bsel];
    wdata     = word;
    used_next = used;
    mem_we    = 1'b0;
    if (req_op == OP_ALLOC) begin
      wdata[bfree] = 1'b1;
      if (alloc_fit) begin
        mem_we = (state == S_MOD);
        if (used < UW'(MAP_BITS)) begin
          used_next = used + UW'(1);
        end
      end
    end else begin
      wdata[bsel] = 1'b0;
      if (rel_hit) begin
        mem_we = (state == S_MOD);
        if (used != '0) begin
          used_next = used - UW'(1);
        end
      end
    end
  end

  // map memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  // sequencer, summary bits and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      used          <= '0;
      full          <= '0;
      valid         <= '0;
      result_number <= '0;
      status        <= ST_OK;
      free_count    <= '0;
    end else begin
      done   <= 1'b0;
      rvalid <= valid[addr];
      case (state)
        S_IDLE: begin
          if (start) begin
            req_op <= op;
            lim_q  <= eff_lim;
            if (op == OP_ALLOC) begin
              state <= S_GRP;
            end else if (num_ext == '0 || num_ext > eff_lim) begin
              done          <= 1'b1;
              result_number <= '0;
              status        <= ST_RANGE;
              free_count    <= FIELD_W'(sat_free(eff_lim, used));
            end else begin
              addr  <= n1[KW-1:BW];
              bsel  <= n1[BW-1:0];
              state <= S_READ;
            end
          end
        end
        S_GRP: begin
          if (gany) begin
            gsel  <= gidx;
            state <= S_WORD;
          end else begin
            done          <= 1'b1;
            result_number <= '0;
            status        <= ST_FULL;
            free_count    <= FIELD_W'(sat_free(lim_q, used));
            state         <= S_IDLE;
          end
        end
        S_WORD: begin
          addr  <= widx[AW-1:0];
          state <= S_READ;
        end
        S_READ: begin
          state <= S_MOD;
        end
        S_MOD: begin
          done       <= 1'b1;
          used       <= used_next;
          free_count <= FIELD_W'(sat_free(lim_q, used_next));
          if (mem_we) begin
            valid[addr] <= 1'b1;
            full[addr]  <= &wdata;
          end
          if (req_op == OP_ALLOC) begin
            if (alloc_fit) begin
              result_number <= FIELD_W'(k_ext + CW'(1));
              status        <= ST_OK;
            end else begin
              result_number <= '0;
              status        <= ST_FULL;
            end
          end else begin
            result_number <= '0;
            status        <= ST_OK;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb.sv
// tb: self-checking bench for the bitmap first-fit allocator, with a local
// model of the free map, used count and limit that predicts every result beat.
// Depends on bffa_pkg and bitmap_first_fit_allocator_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bffa_pkg::*;

  localparam int MAP_NUMS      = 8192;
  localparam int WORD_W        = 32;
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_SEGS   = 5;
  localparam int SEG_ITEMS     = 126;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_CYCLES    = 400000;

  // one expected result beat
  typedef struct packed {
    logic [FIELD_W-1:0] num;
    status_t            st;
    logic [FIELD_W-1:0] free;
  } alloc_result_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  op_t                op          = OP_ALLOC;
  logic [FIELD_W-1:0] number      = '0;
  logic               limit_we    = 1'b0;
  logic [FIELD_W-1:0] limit_wdata = '0;
  logic                busy;
  logic                done;
  logic [FIELD_W-1:0]  result_number;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  free_count;

  // local copy of the allocator state
  logic [MAP_NUMS-1:0] in_use       = '0;
  int unsigned         used_total   = 0;
  logic [FIELD_W-1:0]  limit_shadow = LIMIT_RESET;

  alloc_result_t pending_results[$];
  int unsigned   mismatches  = 0;
  int unsigned   cycle_count = 0;
  int            idle_pct    = 0;

  bitmap_first_fit_allocator_top #(
    .MAP_BITS (MAP_NUMS),
    .WORD_BITS(WORD_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .number       (number),
    .limit_we     (limit_we),
    .limit_wdata  (limit_wdata),
    .done         (done),
    .result_number(result_number),
    .status       (status),
    .free_count   (free_count)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // numbers actually managed: the limit saturates at the map size
  function automatic int unsigned managed_count();
    return (limit_shadow > MAP_NUMS) ? MAP_NUMS : int'(limit_shadow);
  endfunction

  // apply one request to the local state and return its result beat
  function automatic alloc_result_t apply_request(op_t o, logic [FIELD_W-1:0] n);
    alloc_result_t r;
    int unsigned   lim;
    lim   = managed_count();
    r.num = '0;
    r.st  = ST_OK;
    if (o == OP_ALLOC) begin
      r.st = ST_FULL;
      for (int k = 0; k < lim; k++) begin
        if (!in_use[k]) begin
          in_use[k] = 1'b1;
          if (used_total < MAP_NUMS) used_total++;
          r.num = FIELD_W'(k + 1);
          r.st  = ST_OK;
          break;
        end
      end
    end else if (n == 0 || n > lim) begin
      r.st = ST_RANGE;
    end else if (in_use[n-1]) begin
      in_use[n-1] = 1'b0;
      if (used_total > 0) used_total--;
    end
    r.free = (lim > used_total) ? FIELD_W'(lim - used_total) : '0;
    return r;
  endfunction

  // random limit, weighted toward small maps
  function automatic logic [FIELD_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FIELD_W'(MAP_NUMS);
      2: return '1;
      3: return FIELD_W'($urandom_range(MAP_NUMS + 1, (1 << FIELD_W) - 1));
      4: return FIELD_W'($urandom);
      5, 6: return FIELD_W'($urandom_range(49, 300));
      default: return FIELD_W'($urandom_range(1, 48));
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected beat num %0d status %0d free %0d",
                                result_number, status, free_count));
      end else begin
        want = pending_results.pop_front();
        if (result_number !== want.num || status !== want.st ||
            free_count !== want.free)
          note_mismatch($sformatf(
            "expected num %0d status %0d free %0d, got num %0d status %0d free %0d",
            want.num, want.st, want.free, result_number, status, free_count));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one request beat, then a random idle gap on the request side
  task automatic send_request(op_t o, logic [FIELD_W-1:0] n);
    start  <= 1'b1;
    op     <= o;
    number <= n;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(o, n));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // wait until every predicted beat has come back, then let the block go quiet
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_limit(logic [FIELD_W-1:0] value);
    settle();
    limit_we    <= 1'b1;
    limit_wdata <= value;
    @(posedge clk);
    limit_shadow = value;
    limit_we    <= 1'b0;
  endtask

  // field extremes, both operations and every special case
  task automatic test_directed_cases();
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_RELEASE, '0);
    send_request(OP_RELEASE, FIELD_W'(MAP_NUMS + 1));
    send_request(OP_RELEASE, '1);
    send_request(OP_RELEASE, FIELD_W'(2));
    // release of a number that is already free
    send_request(OP_RELEASE, FIELD_W'(2));
    send_request(OP_ALLOC, FIELD_W'(14'h2aaa));
    send_request(OP_RELEASE, FIELD_W'(MAP_NUMS));
    // small map run to full
    program_limit(FIELD_W'(3));
    send_request(OP_ALLOC, FIELD_W'(14'h1555));
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, FIELD_W'(3));
    send_request(OP_RELEASE, FIELD_W'(4));
    send_request(OP_ALLOC, '0);
    // limit lowered below numbers in use
    program_limit(FIELD_W'(1));
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, FIELD_W'(2));
    send_request(OP_RELEASE, FIELD_W'(1));
    send_request(OP_ALLOC, '0);
    // nothing managed
    program_limit('0);
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, FIELD_W'(1));
    // limit above the map size saturates
    program_limit('1);
    send_request(OP_RELEASE, FIELD_W'(2));
    send_request(OP_RELEASE, FIELD_W'(3));
    send_request(OP_RELEASE, FIELD_W'(MAP_NUMS));
    send_request(OP_ALLOC, '0);
  endtask

  // random requests over several limits with the given request-side idle rate
  task automatic test_random_traffic(int pct);
    int unsigned lim;
    int unsigned hi;
    int unsigned pick;
    idle_pct = pct;
    for (int s = 0; s < RANDOM_SEGS; s++) begin
      program_limit((s == RANDOM_SEGS - 1) ? FIELD_W'(MAP_NUMS) : pick_limit());
      lim = managed_count();
      for (int i = 0; i < SEG_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        // releases mostly aim at numbers that may be in use
        hi = (used_total + 6 < lim) ? used_total + 6 : lim + 2;
        if (pick < 50)
          send_request(OP_ALLOC, FIELD_W'($urandom));
        else if (pick < 85)
          send_request(OP_RELEASE, FIELD_W'($urandom_range(1, hi)));
        else if (pick < 92)
          send_request(OP_RELEASE, '0);
        else
          send_request(OP_RELEASE, FIELD_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(15);
    test_random_traffic(83);
    test_random_traffic(0);
    settle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
